### design/rvb_pkg.sv
// ----------------------------------------------------------------------------
// Reverb package
// Shared types, codes and sizes of the multi-tap feedback delay reverb unit.
// ----------------------------------------------------------------------------
package rvb_pkg;

   localparam int LINE_COUNT  = 8;
   localparam int LINE_W      = 3;
   localparam int STORE_AW    = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   localparam logic [1:0] MODE_FRAME = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic [1:0] FIELD_FIRST  = 2'd0;
   localparam logic [1:0] FIELD_LAST   = 2'd1;
   localparam logic [1:0] FIELD_LEVELS = 2'd2;
   localparam logic [1:0] FIELD_CUTOFF = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
      logic [4:0]         reg_addr;
      logic [15:0]        reg_data;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic [15:0]        read_data;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_FRAME,
      OP_WRITE,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [LINE_W-1:0]  line;
      logic [1:0]         field;
      logic [15:0]        data;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_FILTER,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

### design/rvb_front.sv
// ----------------------------------------------------------------------------
// Reverb front end
// Accepts request words, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module rvb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             req_valid,
   output logic             req_ready,
   input  rvb_pkg::req_type req_data,
   output logic             deq_valid,
   input  logic             deq_ready,
   output rvb_pkg::cmd_type deq_cmd
);

   rvb_pkg::cmd_type                queue_ff [rvb_pkg::QUEUE_DEPTH];
   logic [rvb_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rvb_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rvb_pkg::QUEUE_CW-1:0]    count_ff, count_in;
   rvb_pkg::cmd_type                cmd;
   logic                            push;
   logic                            pop;

   always_comb begin
      cmd.left  = req_data.left_in;
      cmd.right = req_data.right_in;
      cmd.line  = req_data.reg_addr[4:2];
      cmd.field = req_data.reg_addr[1:0];
      cmd.data  = req_data.reg_data;
      case (req_data.mode)
         rvb_pkg::MODE_FRAME: cmd.op = rvb_pkg::OP_FRAME;
         rvb_pkg::MODE_WRITE: cmd.op = rvb_pkg::OP_WRITE;
         rvb_pkg::MODE_READ:  cmd.op = rvb_pkg::OP_READ;
         default:             cmd.op = rvb_pkg::OP_NOP;
      endcase
   end

   assign req_ready = enable && (count_ff != rvb_pkg::QUEUE_CW'(rvb_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign deq_valid = (count_ff != '0);
   assign pop       = deq_valid && deq_ready;
   assign deq_cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### design/rvb_back.sv
// ----------------------------------------------------------------------------
// Reverb back end
// Runs the delay lines over the shared sample store, serves line register writes and reads, and holds the response.
// ----------------------------------------------------------------------------
module rvb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             wet_enable,
   output logic             clearing,
   input  logic             deq_valid,
   output logic             deq_ready,
   input  rvb_pkg::cmd_type deq_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rvb_pkg::rsp_type rsp_data
);

   rvb_pkg::state_type            state_ff, state_in;
   rvb_pkg::cmd_type              cmd_ff;
   logic [rvb_pkg::LINE_W-1:0]    line_ff;
   logic [rvb_pkg::STORE_AW-1:0]  clear_ff;
   logic [15:0]                   first_ff [rvb_pkg::LINE_COUNT];
   logic [15:0]                   last_ff [rvb_pkg::LINE_COUNT];
   logic [15:0]                   levels_ff [rvb_pkg::LINE_COUNT];
   logic [15:0]                   cutoff_ff [rvb_pkg::LINE_COUNT];
   logic [15:0]                   pos_ff [rvb_pkg::LINE_COUNT];
   logic [31:0]                   acc_ff [rvb_pkg::LINE_COUNT];
   logic [15:0]                   mem [2**rvb_pkg::STORE_AW];
   logic [15:0]                   rdata_ff;
   logic signed [15:0]            out_s_ff;
   logic signed [15:0]            fb_s_ff;
   logic [31:0]                   prod_ff;
   logic signed [15:0]            left_ff;
   logic signed [15:0]            right_ff;
   logic [15:0]                   read_ff;
   logic                          rsp_valid_ff;
   rvb_pkg::rsp_type              rsp_data_ff;

   logic [rvb_pkg::LINE_W-1:0]    idx;
   logic                          rsp_free;
   logic                          take;
   logic                          mem_we;
   logic [rvb_pkg::STORE_AW-1:0]  mem_waddr;
   logic [rvb_pkg::STORE_AW-1:0]  mem_raddr;
   logic [15:0]                   mem_wdata;
   logic signed [24:0]            vol_prod;
   logic signed [24:0]            fb_prod;
   logic signed [15:0]            fb_dec;
   logic signed [15:0]            feed;
   logic signed [15:0]            ch_in;
   logic signed [16:0]            diff;
   logic signed [33:0]            lp_prod;
   logic [31:0]                   acc_new;
   logic [15:0]                   rd_value;

   assign idx       = (state_ff == rvb_pkg::ST_IDLE) ? deq_cmd.line : line_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign take      = deq_valid && (state_ff == rvb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rvb_pkg::ST_CLEAR: begin
            if (clear_ff == '1) begin
               state_in = rvb_pkg::ST_IDLE;
            end
         end
         rvb_pkg::ST_IDLE: begin
            if (deq_valid) begin
               if (deq_cmd.op == rvb_pkg::OP_FRAME && wet_enable) begin
                  state_in = rvb_pkg::ST_READ;
               end else begin
                  state_in = rvb_pkg::ST_DONE;
               end
            end
         end
         rvb_pkg::ST_READ:   state_in = rvb_pkg::ST_MUL;
         rvb_pkg::ST_MUL:    state_in = rvb_pkg::ST_FILTER;
         rvb_pkg::ST_FILTER: state_in = rvb_pkg::ST_ACC;
         rvb_pkg::ST_ACC: begin
            if (line_ff == rvb_pkg::LINE_W'(rvb_pkg::LINE_COUNT - 1)) begin
               state_in = rvb_pkg::ST_DONE;
            end else begin
               state_in = rvb_pkg::ST_READ;
            end
         end
         rvb_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = rvb_pkg::ST_IDLE;
            end
         end
         default: state_in = rvb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ch_in     = line_ff[0] ? cmd_ff.right : cmd_ff.left;
      feed      = {{2{ch_in[15]}}, ch_in[15:2]};
      fb_dec    = fb_s_ff;
      if (fb_s_ff > 16'sd0) begin
         fb_dec = fb_s_ff - 16'sd1;
      end else if (fb_s_ff < 16'sd0) begin
         fb_dec = fb_s_ff + 16'sd1;
      end
      vol_prod  = $signed(rdata_ff) * $signed({1'b0, levels_ff[line_ff][7:0]});
      fb_prod   = $signed(rdata_ff) * $signed({1'b0, levels_ff[line_ff][15:8]});
      diff      = {out_s_ff[15], out_s_ff} - $signed({acc_ff[line_ff][31], acc_ff[line_ff][31:16]});
      lp_prod   = diff * $signed({1'b0, cutoff_ff[line_ff]});
      acc_new   = acc_ff[line_ff] + prod_ff;
      mem_raddr = pos_ff[idx][rvb_pkg::STORE_AW-1:0];
      case (deq_cmd.field)
         rvb_pkg::FIELD_FIRST:  rd_value = first_ff[idx];
         rvb_pkg::FIELD_LAST:   rd_value = last_ff[idx];
         rvb_pkg::FIELD_LEVELS: rd_value = levels_ff[idx];
         default:               rd_value = cutoff_ff[idx];
      endcase
   end

   always_comb begin
      deq_ready = (state_ff == rvb_pkg::ST_IDLE);
      clearing  = (state_ff == rvb_pkg::ST_CLEAR);
      mem_we    = (state_ff == rvb_pkg::ST_CLEAR) || (state_ff == rvb_pkg::ST_FILTER);
      mem_waddr = (state_ff == rvb_pkg::ST_CLEAR) ? clear_ff : mem_raddr;
      mem_wdata = (state_ff == rvb_pkg::ST_CLEAR) ? 16'd0 : 16'(fb_dec + feed);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rvb_pkg::ST_CLEAR;
         clear_ff     <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rvb_pkg::LINE_COUNT; i++) begin
            first_ff[i]  <= '0;
            last_ff[i]   <= '0;
            levels_ff[i] <= '0;
            cutoff_ff[i] <= '0;
            pos_ff[i]    <= '0;
            acc_ff[i]    <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == rvb_pkg::ST_CLEAR) begin
            clear_ff <= clear_ff + 1'b1;
         end
         if (take) begin
            line_ff <= '0;
            if (deq_cmd.op == rvb_pkg::OP_WRITE) begin
               case (deq_cmd.field)
                  rvb_pkg::FIELD_FIRST:  first_ff[idx]  <= deq_cmd.data;
                  rvb_pkg::FIELD_LAST:   last_ff[idx]   <= deq_cmd.data;
                  rvb_pkg::FIELD_LEVELS: levels_ff[idx] <= deq_cmd.data;
                  default:               cutoff_ff[idx] <= deq_cmd.data;
               endcase
               pos_ff[idx] <= (deq_cmd.field == rvb_pkg::FIELD_FIRST) ?
                              deq_cmd.data : first_ff[idx];
            end
         end
         if (state_ff == rvb_pkg::ST_FILTER) begin
            pos_ff[line_ff] <= (pos_ff[line_ff] == last_ff[line_ff]) ?
                               first_ff[line_ff] : pos_ff[line_ff] + 16'd1;
         end
         if (state_ff == rvb_pkg::ST_ACC) begin
            acc_ff[line_ff] <= acc_new;
            line_ff         <= line_ff + 1'b1;
         end
         if (state_ff == rvb_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff  <= deq_cmd;
         read_ff <= (deq_cmd.op == rvb_pkg::OP_READ) ? rd_value : 16'd0;
         if (deq_cmd.op == rvb_pkg::OP_FRAME) begin
            left_ff  <= {{2{deq_cmd.left[15]}}, deq_cmd.left[15:2]};
            right_ff <= {{2{deq_cmd.right[15]}}, deq_cmd.right[15:2]};
         end else begin
            left_ff  <= '0;
            right_ff <= '0;
         end
      end
      if (state_ff == rvb_pkg::ST_MUL) begin
         out_s_ff <= vol_prod[23:8];
         fb_s_ff  <= fb_prod[23:8];
      end
      if (state_ff == rvb_pkg::ST_FILTER) begin
         prod_ff <= lp_prod[31:0];
      end
      if (state_ff == rvb_pkg::ST_ACC) begin
         if (line_ff[0]) begin
            right_ff <= right_ff + $signed(acc_new[31:16]);
         end else begin
            left_ff <= left_ff + $signed(acc_new[31:16]);
         end
      end
      if (state_ff == rvb_pkg::ST_DONE && rsp_free) begin
         rsp_data_ff.left_out  <= left_ff;
         rsp_data_ff.right_out <= right_ff;
         rsp_data_ff.read_data <= read_ff;
      end
   end

endmodule

### design/multi_tap_feedback_delay_reverb_unit.sv
// ----------------------------------------------------------------------------
// Multi-tap feedback delay reverb unit
// Stereo reverb built from eight delay lines over one shared sample store.
//
// A request word on req_ carries a stereo frame, a line register write or a
// line register read. Every request gives exactly one response word on rsp_,
// in request order. csr_ writes the wet enable bit; it is always ready.
// A frame with wet enable set runs the eight lines one after another, as set
// by the single sample store port pair, through the read, multiply, filter
// and accumulate steps of each line, before its response is loaded.
// Dry frames, writes and reads skip those steps and go straight to the response.
// A two-word queue takes requests while the engine is busy, and the
// response register holds a finished word while the receiver stalls; the
// engine then waits before it loads the next response.
// After reset the sample store is cleared, one word a cycle, all 65536
// words; req_ready stays low until that pass is done.
// ----------------------------------------------------------------------------
module multi_tap_feedback_delay_reverb_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rvb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rvb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   logic             wet_enable_ff;
   logic             clearing;
   logic             deq_valid;
   logic             deq_ready;
   rvb_pkg::cmd_type deq_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         wet_enable_ff <= csr_data;
      end
   end

   rvb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (!clearing),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_cmd   (deq_cmd)
   );

   rvb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .wet_enable (wet_enable_ff),
      .clearing   (clearing),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_cmd    (deq_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
